FILE: rtl/core/rdci_pkg.sv
// Shared types, constants and saturation helpers for the ray/double-cone intersect core.
package rdci_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int S_TDATA_W = 224;
	localparam int M_TDATA_W = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int SW = 68;

	localparam logic signed [SW-1:0] SAT_HI = 68'sd2147483647;
	localparam logic signed [SW-1:0] SAT_LO = -68'sd2147483648;

	// Entry handed from the coefficient front end to the solver back end
	typedef struct packed {
		logic               miss;
		logic               dzero;
		logic [30:0]        disc;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] dy;
		logic signed [31:0] py;
		logic [30:0]        tmax;
	} fe_t;

	function automatic logic signed [SW-1:0] sx32(input logic signed [31:0] v);
		return {{(SW-32){v[31]}}, v};
	endfunction

	function automatic logic signed [SW-1:0] sx64(input logic signed [63:0] v);
		return {{(SW-64){v[63]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/rdci_front.sv
// Front end: apex shift, quadratic coefficients and discriminant, five pipeline stages.
module rdci_front import rdci_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [S_TDATA_W-1:0] in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fe_t                  out_entry
);

	localparam logic signed [SW-1:0] ONE_F = 68'sd1 <<< FRAC_BITS;

	logic en;

	logic               v_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1, dx_s1, dy_s1, dz_s1;
	logic [30:0]        tmax_s1;

	logic               v_s2;
	logic signed [63:0] m_s2 [9];
	logic signed [31:0] dy_s2, py_s2;
	logic [30:0]        tmax_s2;

	logic               v_s3;
	logic signed [31:0] a_s3, b_s3, c_s3, dy_s3, py_s3;
	logic [30:0]        tmax_s3;

	logic               v_s4;
	logic signed [63:0] bb_s4, ac_s4;
	logic               az_s4;
	logic signed [31:0] a_s4, b_s4, c_s4, dy_s4, py_s4;
	logic [30:0]        tmax_s4;

	logic               v_s5;
	fe_t                ent_s5;

	logic signed [63:0] f2 [9];
	logic signed [SW-1:0] dd2, dp2, pp2;
	logic signed [SW-1:0] disc4;
	logic [30:0]          dsat4;

	assign en        = !v_s5 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s5;
	assign out_entry = ent_s5;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			f2[i] = m_s2[i] >>> FRAC_BITS;
		end
		dd2 = sx64(f2[0]) - sx64(f2[1]) + sx64(f2[2]);
		dp2 = sx64(f2[3]) - sx64(f2[4]) + sx64(f2[5]);
		pp2 = sx64(f2[6]) - sx64(f2[7]) + sx64(f2[8]);
	end

	always_comb begin
		disc4 = sx64(bb_s4 >>> FRAC_BITS) - (sx64(ac_s4 >>> FRAC_BITS) <<< 2);
		if (disc4[SW-1]) begin
			dsat4 = '0;
		end else if (disc4 > SAT_HI) begin
			dsat4 = 31'h7FFFFFFF;
		end else begin
			dsat4 = disc4[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// shift the apex to the origin
			px_s1   <= in_data[31:0];
			py_s1   <= sat32(sx32($signed(in_data[63:32])) + ONE_F);
			pz_s1   <= in_data[95:64];
			dx_s1   <= in_data[127:96];
			dy_s1   <= in_data[159:128];
			dz_s1   <= in_data[191:160];
			tmax_s1 <= in_data[222:192];

			m_s2[0] <= dx_s1 * dx_s1;
			m_s2[1] <= dy_s1 * dy_s1;
			m_s2[2] <= dz_s1 * dz_s1;
			m_s2[3] <= dx_s1 * px_s1;
			m_s2[4] <= dy_s1 * py_s1;
			m_s2[5] <= dz_s1 * pz_s1;
			m_s2[6] <= px_s1 * px_s1;
			m_s2[7] <= py_s1 * py_s1;
			m_s2[8] <= pz_s1 * pz_s1;
			dy_s2   <= dy_s1;
			py_s2   <= py_s1;
			tmax_s2 <= tmax_s1;

			a_s3    <= sat32(dd2);
			b_s3    <= sat32(dp2 <<< 1);
			c_s3    <= sat32(pp2);
			dy_s3   <= dy_s2;
			py_s3   <= py_s2;
			tmax_s3 <= tmax_s2;

			bb_s4   <= b_s3 * b_s3;
			ac_s4   <= a_s3 * c_s3;
			az_s4   <= (a_s3 == 32'sd0);
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			c_s4    <= c_s3;
			dy_s4   <= dy_s3;
			py_s4   <= py_s3;
			tmax_s4 <= tmax_s3;

			ent_s5.miss  <= disc4[SW-1] || az_s4;
			ent_s5.dzero <= (dsat4 == 31'd0);
			ent_s5.disc  <= dsat4;
			ent_s5.a     <= a_s4;
			ent_s5.b     <= b_s4;
			ent_s5.c     <= c_s4;
			ent_s5.dy    <= dy_s4;
			ent_s5.py    <= py_s4;
			ent_s5.tmax  <= tmax_s4;
		end
	end

endmodule

FILE: rtl/core/rdci_queue.sv
// Short register queue between the front end and the solver back end.
module rdci_queue import rdci_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fe_t  push_entry,
	input  logic pop,
	output fe_t  head_entry,
	output logic full,
	output logic empty
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	fe_t           mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign full       = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign empty      = (cnt_q == '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue read while empty");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + (AW+1)'($past(push)) - (AW+1)'($past(pop)))
		else $error("queue count out of step with push and pop");

endmodule

FILE: rtl/core/rdci_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
module rdci_sqrt import rdci_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SIDE_W = 1,
	localparam int IN_W = 31 + FRAC_BITS,
	localparam int N = (IN_W + 1) / 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [N-1:0]      out_root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int PW = 2 * N;
	localparam int RW = N + 3;

	logic              vld_q  [N];
	logic [PW-1:0]     rad_q  [N];
	logic [RW-3:0]     rem_q  [N];
	logic [N-1:0]      root_q [N];
	logic [SIDE_W-1:0] side_q [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic              vld_i;
		logic [PW-1:0]     rad_i;
		logic [RW-3:0]     rem_i;
		logic [N-1:0]      root_i;
		logic [SIDE_W-1:0] side_i;
		logic [RW-1:0]     cur, trial, diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_i  = in_valid;
			assign rad_i  = PW'(in_rad);
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_q[k-1];
			assign rad_i  = rad_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign side_i = side_q[k-1];
		end

		// bring down two radicand bits, try root*4+1
		assign cur   = {rem_i, rad_i[PW-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign diff  = cur - trial;
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k]  <= rad_i << 2;
				rem_q[k]  <= ge ? diff[RW-3:0] : cur[RW-3:0];
				root_q[k] <= {root_i[N-2:0], ge};
				side_q[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_q[N-1];
	assign out_root  = root_q[N-1];
	assign out_side  = side_q[N-1];

endmodule

FILE: rtl/core/rdci_div.sv
// Pipelined restoring divider on magnitudes: (num << FRAC_BITS) / den, one bit per stage.
module rdci_div import rdci_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SIDE_W = 1,
	localparam int DW = 32 + FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [31:0]       in_num,
	input  logic [31:0]       in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [DW-1:0]     out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_q  [DW];
	logic [DW-1:0]     dvd_q  [DW];
	logic [DW-1:0]     quo_q  [DW];
	logic [31:0]       rem_q  [DW];
	logic [31:0]       den_q  [DW];
	logic [SIDE_W-1:0] side_q [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic              vld_i;
		logic [DW-1:0]     dvd_i, quo_i;
		logic [31:0]       rem_i, den_i;
		logic [SIDE_W-1:0] side_i;
		logic [32:0]       cur, diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_i  = in_valid;
			assign dvd_i  = {in_num, {FRAC_BITS{1'b0}}};
			assign quo_i  = '0;
			assign rem_i  = '0;
			assign den_i  = in_den;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_q[k-1];
			assign dvd_i  = dvd_q[k-1];
			assign quo_i  = quo_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign den_i  = den_q[k-1];
			assign side_i = side_q[k-1];
		end

		assign cur  = {rem_i, dvd_i[DW-1]};
		assign diff = cur - {1'b0, den_i};
		assign ge   = (cur >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_q[k]  <= dvd_i << 1;
				quo_q[k]  <= {quo_i[DW-2:0], ge};
				rem_q[k]  <= ge ? diff[31:0] : cur[31:0];
				den_q[k]  <= den_i;
				side_q[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_q[DW-1];
	assign out_quo   = quo_q[DW-1];
	assign out_side  = side_q[DW-1];

endmodule

FILE: rtl/core/rdci_back.sv
// Back end: square root, q, both root divisions, root fixup and nappe selection.
module rdci_back import rdci_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  fe_t         in_entry,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_hit,
	output logic [30:0] out_dist
);

	localparam int IN_W = 31 + FRAC_BITS;
	localparam int N = (IN_W + 1) / 2;
	localparam int DW = 32 + FRAC_BITS;
	localparam logic [DW-1:0] QMAX = DW'(33'h07FFFFFFF);
	localparam logic [DW-1:0] QMIN = DW'(33'h080000000);

	typedef struct packed {
		logic               miss;
		logic               dzero;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] dy;
		logic signed [31:0] py;
		logic [30:0]        tmax;
	} bs_t;

	typedef struct packed {
		logic               miss;
		logic               neg;
		logic signed [31:0] dy;
		logic signed [31:0] py;
		logic [30:0]        tmax;
	} dv_t;

	function automatic logic signed [31:0] quo_fix(input logic [DW-1:0] m, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			r = (m > QMIN) ? 32'sh80000000 : $signed(~m[31:0] + 32'd1);
		end else begin
			r = (m > QMAX) ? 32'sh7FFFFFFF : $signed(m[31:0]);
		end
		return r;
	endfunction

	function automatic logic [31:0] mag(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	logic en;

	bs_t          sq_in_side, sq_side;
	logic         sq_valid;
	logic [N-1:0] sq_root;

	logic               vld_s1;
	logic signed [31:0] q_s1;
	bs_t                side_s1;

	logic               vld_s2;
	logic [31:0]        num1_s2, den1_s2, num2_s2, den2_s2;
	dv_t                side_s2;
	logic               neg2_s2;

	logic          dv1_valid, dv2_valid;
	logic [DW-1:0] quo1, quo2;
	dv_t           dv_side;
	logic          dv_neg2;

	logic               vld_s3;
	logic signed [31:0] r1_s3, r2_s3;
	dv_t                side_s3;

	logic               vld_s4, miss_s4;
	logic signed [31:0] r1_s4, r2_s4, dy_s4, py_s4;
	logic [30:0]        tmax_s4;

	logic               vld_s5, miss_s5;
	logic signed [63:0] m1_s5, m2_s5;
	logic signed [31:0] r1_s5, r2_s5, py_s5;
	logic [30:0]        tmax_s5;

	logic               vld_s6, hit_s6;
	logic [30:0]        dist_s6;

	logic signed [33:0] s_ext, b_ext, x0, qf0;
	logic signed [31:0] hb1, n1_1, d1_1, n2_1, d2_1;
	logic               miss1;
	logic               p1_3, p2_3, miss3;
	logic signed [31:0] r1f3, r2f3, tmx3;
	logic signed [SW-1:0] y1_5, y2_5;
	logic               same5;
	logic signed [31:0] pick5;

	assign en        = !vld_s6 || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s6;
	assign out_hit   = hit_s6;
	assign out_dist  = dist_s6;

	always_comb begin
		sq_in_side.miss  = in_entry.miss;
		sq_in_side.dzero = in_entry.dzero;
		sq_in_side.a     = in_entry.a;
		sq_in_side.b     = in_entry.b;
		sq_in_side.c     = in_entry.c;
		sq_in_side.dy    = in_entry.dy;
		sq_in_side.py    = in_entry.py;
		sq_in_side.tmax  = in_entry.tmax;
	end

	rdci_sqrt #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(bs_t))) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_rad    ({in_entry.disc, {FRAC_BITS{1'b0}}}),
		.in_side   (sq_in_side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// q = -floor((b +/- s) / 2), sign of s follows b
	always_comb begin
		s_ext = $signed({{(34-N){1'b0}}, sq_root});
		b_ext = {{2{sq_side.b[31]}}, sq_side.b};
		x0    = (sq_side.b > 32'sd0) ? (b_ext + s_ext) : (b_ext - s_ext);
		qf0   = -(x0 >>> 1);
	end

	// zero discriminant: both roots are -floor(b/2) / a
	always_comb begin
		hb1   = -(side_s1.b >>> 1);
		n1_1  = side_s1.dzero ? hb1 : q_s1;
		d1_1  = side_s1.a;
		n2_1  = side_s1.dzero ? hb1 : side_s1.c;
		d2_1  = side_s1.dzero ? side_s1.a : q_s1;
		miss1 = side_s1.miss || (!side_s1.dzero && q_s1 == 32'sd0);
	end

	rdci_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(dv_t))) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_num    (num1_s2),
		.in_den    (den1_s2),
		.in_side   (side_s2),
		.out_valid (dv1_valid),
		.out_quo   (quo1),
		.out_side  (dv_side)
	);

	rdci_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_num    (num2_s2),
		.in_den    (den2_s2),
		.in_side   (neg2_s2),
		.out_valid (dv2_valid),
		.out_quo   (quo2),
		.out_side  (dv_neg2)
	);

	// replace a non-positive root by the other, drop rays beyond max distance
	always_comb begin
		p1_3  = (r1_s3 > 32'sd0);
		p2_3  = (r2_s3 > 32'sd0);
		r1f3  = p1_3 ? r1_s3 : r2_s3;
		r2f3  = p2_3 ? r2_s3 : r1_s3;
		tmx3  = $signed({1'b0, side_s3.tmax});
		miss3 = side_s3.miss || (!p1_3 && !p2_3) || (r1f3 > tmx3 && r2f3 > tmx3);
	end

	// same nappe when both heights share a sign, zero counting as either
	always_comb begin
		y1_5  = sx64(m1_s5 >>> FRAC_BITS) + sx32(py_s5);
		y2_5  = sx64(m2_s5 >>> FRAC_BITS) + sx32(py_s5);
		same5 = (!y1_5[SW-1] && !y2_5[SW-1]) ||
			((y1_5[SW-1] || y1_5 == '0) && (y2_5[SW-1] || y2_5 == '0));
		if (same5) begin
			pick5 = (r1_s5 < r2_s5) ? r1_s5 : r2_s5;
		end else begin
			pick5 = (r1_s5 > r2_s5) ? r1_s5 : r2_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sq_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= dv1_valid && dv2_valid;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1    <= sat32({{(SW-34){qf0[33]}}, qf0});
			side_s1 <= sq_side;

			num1_s2      <= mag(n1_1);
			den1_s2      <= mag(d1_1);
			num2_s2      <= mag(n2_1);
			den2_s2      <= mag(d2_1);
			neg2_s2      <= n2_1[31] ^ d2_1[31];
			side_s2.miss <= miss1;
			side_s2.neg  <= n1_1[31] ^ d1_1[31];
			side_s2.dy   <= side_s1.dy;
			side_s2.py   <= side_s1.py;
			side_s2.tmax <= side_s1.tmax;

			r1_s3   <= quo_fix(quo1, dv_side.neg);
			r2_s3   <= quo_fix(quo2, dv_neg2);
			side_s3 <= dv_side;

			r1_s4   <= r1f3;
			r2_s4   <= r2f3;
			miss_s4 <= miss3;
			dy_s4   <= side_s3.dy;
			py_s4   <= side_s3.py;
			tmax_s4 <= side_s3.tmax;

			m1_s5   <= dy_s4 * r1_s4;
			m2_s5   <= dy_s4 * r2_s4;
			r1_s5   <= r1_s4;
			r2_s5   <= r2_s4;
			py_s5   <= py_s4;
			miss_s5 <= miss_s4;
			tmax_s5 <= tmax_s4;

			hit_s6  <= !miss_s5;
			dist_s6 <= miss_s5 ? tmax_s5 : pick5[30:0];
		end
	end

endmodule

FILE: rtl/core/ray_double_cone_intersect_core.sv
// Top level of the ray against unit double cone intersection core.
//
//  channel  | dir | fields (low bit first)
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
//           |     |        max_distance, zero pad to 224 bits
//  m_axis   | out | tdata: distance, zero pad to 32 bits; tuser: hit
//
// One beat per cycle sustained while m_tready stays high; no reset sweep, reset only
// clears valid bits, queue pointers and the queue count. Pipeline depth is set by the
// bit-per-stage square root and the bit-per-stage root dividers.
// A stall on m_tready freezes the solver pipe; the coefficient pipe keeps taking beats
// until its own stages and the four-entry queue fill, then s_tready drops.
module ray_double_cone_intersect_core import rdci_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y,
	                                        // dir_z, max_distance, pad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // distance, pad
	output logic [0:0]           m_tuser   // hit
);

	logic        fr_valid, q_full, q_empty, bk_ready;
	fe_t         fr_entry, q_head;
	logic        hit;
	logic [30:0] hit_dist;

	rdci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.out_valid (fr_valid),
		.out_ready (!q_full),
		.out_entry (fr_entry)
	);

	rdci_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fr_valid && !q_full),
		.push_entry (fr_entry),
		.pop        (bk_ready && !q_empty),
		.head_entry (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	rdci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!q_empty),
		.in_ready  (bk_ready),
		.in_entry  (q_head),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hit   (hit),
		.out_dist  (hit_dist)
	);

	assign m_tdata = {1'b0, hit_dist};
	assign m_tuser = hit;

endmodule
